// File: rtl/spmfs_pkg.sv
// shared codes for the strict priority multi-queue scheduler
package spmfs_pkg;

    // operation field of an input word
    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TAKE = 1'b1
    } op_t;

    // status field of a result word
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam int unsigned LEVEL_FIELD_W = 3;
    localparam int unsigned ID_FIELD_W    = 8;

endpackage

// File: rtl/spmfs_entry_ram.sv
// entry store: one write port, one read port, registered read data
module spmfs_entry_ram #(
    parameter int unsigned DEPTH  = 128,
    parameter int unsigned ADDR_W = 7,
    parameter int unsigned DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/spmfs_level_pick.sv
// lowest-numbered non-empty level finder
module spmfs_level_pick #(
    parameter int unsigned NUM_LEVELS = 8,
    parameter int unsigned LVL_W      = 3
) (
    input  logic [NUM_LEVELS-1:0] nonempty,
    output logic                  found,
    output logic [LVL_W-1:0]      level
);

    always_comb
    begin
        level = '0;
        // walk from the top so the lowest set level wins
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                level = LVL_W'(i);
            end
        end
    end

    assign found = |nonempty;

endmodule

// File: rtl/strict_priority_multi_fifo_scheduler.sv
// strict priority scheduler: one task fifo per level, top level
//
// Keeps one first-in first-out queue of task ids per priority level, all
// queues sharing a single entry store. An add word appends task_id to the
// queue of priority_req and answers status ok, or status full (nothing
// stored) when that queue already holds LEVEL_DEPTH ids or the level does
// not exist. A take word removes the oldest id of the lowest-numbered
// non-empty level (level 0 is most urgent) and returns it with its level;
// when every queue is empty it answers status empty with id and level 0.
// Every input word yields exactly one result word, in order. Throughput is
// one word per clock while in_stall is low: head/tail/count for all levels
// sit in flops and are updated in the accept cycle, while the entry store
// takes either one write (add) or one read (take) that same cycle. A result
// word passes through the store read stage and then the output register
// before out_valid shows it. in_stall rises only when the read stage is
// occupied and the output register is full and stalled. Store entries have
// no reset; a take only ever reads an entry that an earlier add wrote, so
// no clearing pass is needed.
module strict_priority_multi_fifo_scheduler #(
    parameter int unsigned NUM_LEVELS  = 8,
    parameter int unsigned LEVEL_DEPTH = 16,
    parameter int unsigned ID_BITS     = 8
) (
    input  logic       clk,
    input  logic       rst_n,

    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [2:0] priority_req,
    input  logic [7:0] task_id,

    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] chosen_id,
    output logic [2:0] chosen_level
);

    localparam int unsigned LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int unsigned PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int unsigned CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int unsigned ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
    localparam int unsigned ADDR_W  = $clog2(ENTRIES);
    localparam int unsigned FLD_W   = spmfs_pkg::LEVEL_FIELD_W;
    localparam int unsigned IDF_W   = spmfs_pkg::ID_FIELD_W;

    // per-level queue pointers and fill counts
    logic [PTR_W-1:0] head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] head_next [NUM_LEVELS];
    logic [PTR_W-1:0] tail_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] tail_next [NUM_LEVELS];
    logic [CNT_W-1:0] count_reg [NUM_LEVELS];
    logic [CNT_W-1:0] count_next[NUM_LEVELS];

    // read stage (store read in flight)
    logic                  p1_valid_reg;
    spmfs_pkg::status_t    p1_status_reg;
    logic                  p1_hit_reg;
    logic [FLD_W-1:0]      p1_level_reg;

    // output register
    logic                  out_valid_reg;
    spmfs_pkg::status_t    status_reg;
    logic [IDF_W-1:0]      chosen_id_reg;
    logic [FLD_W-1:0]      chosen_level_reg;

    logic                  accept;
    logic                  advance;
    logic                  is_take;
    logic                  lvl_exists;
    logic [LVL_W+FLD_W-1:0] req_wide;
    logic [LVL_W-1:0]      add_lvl;
    logic                  add_full;
    logic                  do_write;
    logic                  do_read;
    logic [NUM_LEVELS-1:0] nonempty;
    logic                  any_ready;
    logic [LVL_W-1:0]      pick_lvl;
    logic [LVL_W+FLD_W-1:0] pick_wide;
    logic [ID_BITS+IDF_W-1:0] id_in_wide;
    logic [ID_BITS-1:0]    id_in;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic [ID_BITS-1:0]    rdata;
    logic [ID_BITS+IDF_W-1:0] rdata_wide;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(LEVEL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // handshake: the read stage frees up when the output register can load
    assign advance  = p1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = p1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign is_take  = (operation == spmfs_pkg::OP_TAKE);

    // add side: level decode and full check
    assign lvl_exists = (32'(priority_req) < 32'(NUM_LEVELS));
    assign req_wide   = {{LVL_W{1'b0}}, priority_req};
    assign add_lvl    = req_wide[LVL_W-1:0];
    assign add_full   = !lvl_exists || (count_reg[add_lvl] == CNT_W'(LEVEL_DEPTH));

    // id kept in its low ID_BITS bits
    assign id_in_wide = {{ID_BITS{1'b0}}, task_id};
    assign id_in      = id_in_wide[ID_BITS-1:0];

    // take side: lowest non-empty level
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
        end
    end

    spmfs_level_pick #(
        .NUM_LEVELS (NUM_LEVELS),
        .LVL_W      (LVL_W)
    ) u_pick (
        .nonempty (nonempty),
        .found    (any_ready),
        .level    (pick_lvl)
    );

    assign pick_wide = {{FLD_W{1'b0}}, pick_lvl};

    assign do_write = accept && !is_take && !add_full;
    assign do_read  = accept && is_take && any_ready;

    // level base plus slot gives the store address
    assign waddr = ADDR_W'(ADDR_W'(add_lvl) * ADDR_W'(LEVEL_DEPTH))
                 + ADDR_W'(tail_reg[add_lvl]);
    assign raddr = ADDR_W'(ADDR_W'(pick_lvl) * ADDR_W'(LEVEL_DEPTH))
                 + ADDR_W'(head_reg[pick_lvl]);

    // an add and a take never share a cycle, and a read issued the cycle
    // after a write to the same slot already sees the new data
    spmfs_entry_ram #(
        .DEPTH  (ENTRIES),
        .ADDR_W (ADDR_W),
        .DATA_W (ID_BITS)
    ) u_store (
        .clk   (clk),
        .we    (do_write),
        .waddr (waddr),
        .wdata (id_in),
        .re    (do_read),
        .raddr (raddr),
        .rdata (rdata)
    );

    // pointer and count updates
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
        end
        if (do_write)
        begin
            tail_next[add_lvl]  = bump(tail_reg[add_lvl]);
            count_next[add_lvl] = count_reg[add_lvl] + CNT_W'(1);
        end
        if (do_read)
        begin
            head_next[pick_lvl]  = bump(head_reg[pick_lvl]);
            count_next[pick_lvl] = count_reg[pick_lvl] - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            p1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            p1_valid_reg <= 1'b0;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_hit_reg   <= do_read;
            p1_level_reg <= do_read ? pick_wide[FLD_W-1:0] : '0;
            if (is_take)
            begin
                p1_status_reg <= any_ready ? spmfs_pkg::ST_OK : spmfs_pkg::ST_EMPTY;
            end
            else
            begin
                p1_status_reg <= add_full ? spmfs_pkg::ST_FULL : spmfs_pkg::ST_OK;
            end
        end
    end

    // output register
    assign rdata_wide = {{IDF_W{1'b0}}, rdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg       <= p1_status_reg;
            chosen_id_reg    <= p1_hit_reg ? rdata_wide[IDF_W-1:0] : '0;
            chosen_level_reg <= p1_level_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_id    = chosen_id_reg;
    assign chosen_level = chosen_level_reg;

    // a stall on the input side comes only from a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (p1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without output backpressure");

    // a take that sees a non-empty level must report ok next cycle
    a_take_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_take && any_ready)
            |=> (p1_valid_reg && p1_hit_reg && p1_status_reg == spmfs_pkg::ST_OK))
        else $error("take with ready level not reported ok");

    // an empty answer carries zero id and level
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == spmfs_pkg::ST_EMPTY)
            |-> (chosen_id_reg == '0 && chosen_level_reg == '0))
        else $error("empty result with nonzero id or level");

    // the written level's count grows by one after an add
    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_write |=> (count_reg[$past(add_lvl)] == $past(count_reg[add_lvl]) + CNT_W'(1)))
        else $error("fill count did not track an add");

endmodule

// File: bench/strict_priority_multi_fifo_scheduler_check.sv
// checker for the strict priority scheduler: predicts each result word and compares
`timescale 1ns / 100ps

module strict_priority_multi_fifo_scheduler_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       operation,
    input  logic [2:0] priority_req,
    input  logic [7:0] task_id,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] status,
    input  logic [7:0] chosen_id,
    input  logic [2:0] chosen_level,
    output int         fail_count,
    output int         pending_count
);

    localparam int LEVELS = 8;
    localparam int DEPTH  = 16;

    typedef struct {
        spmfs_pkg::status_t status;
        logic [7:0]         id;
        logic [2:0]         level;
    } answer_t;

    // mirror of the per-level task queues
    logic [7:0] id_store [LEVELS][DEPTH];
    int         head_slot [LEVELS];
    int         tail_slot [LEVELS];
    int         fill [LEVELS];

    answer_t    answers_due[$];
    answer_t    want;

    task automatic report_mismatch(input string what);
        $display("%0t: scheduler mismatch: %s", $time, what);
        fail_count++;
    endtask

    // one input word against the mirrored queues, returns the answer it earns
    function automatic answer_t schedule_word(spmfs_pkg::op_t op, logic [2:0] lvl,
                                              logic [7:0] id);
        answer_t ans;
        int      pick;
        ans.status = spmfs_pkg::ST_OK;
        ans.id     = '0;
        ans.level  = '0;
        pick       = 0;
        if (op == spmfs_pkg::OP_ADD)
        begin
            if (int'(lvl) >= LEVELS || fill[lvl] >= DEPTH)
                ans.status = spmfs_pkg::ST_FULL;
            else
            begin
                id_store[lvl][tail_slot[lvl]] = id;
                tail_slot[lvl] = (tail_slot[lvl] + 1) % DEPTH;
                fill[lvl]++;
            end
        end
        else
        begin
            while (pick < LEVELS && fill[pick] == 0)
                pick++;
            if (pick == LEVELS)
                ans.status = spmfs_pkg::ST_EMPTY;
            else
            begin
                ans.id          = id_store[pick][head_slot[pick]];
                ans.level       = 3'(pick);
                head_slot[pick] = (head_slot[pick] + 1) % DEPTH;
                fill[pick]--;
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_slot[l] = 0;
                tail_slot[l] = 0;
                fill[l]      = 0;
            end
            answers_due.delete();
            fail_count = 0;
            pending_count <= 0;
        end
        else
        begin
            // result words leave first; each word passes the read stage and the output
            // register, so none can belong to a word accepted at this same edge
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                    report_mismatch($sformatf("unrequested result st=%0d id=%0h lvl=%0d",
                                              status, chosen_id, chosen_level));
                else
                begin
                    want = answers_due.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  status, want.status));
                    if (chosen_id !== want.id)
                        report_mismatch($sformatf("chosen_id %0h, wanted %0h",
                                                  chosen_id, want.id));
                    if (chosen_level !== want.level)
                        report_mismatch($sformatf("chosen_level %0d, wanted %0d",
                                                  chosen_level, want.level));
                end
            end
            if (in_valid && !in_stall)
                answers_due.push_back(schedule_word(spmfs_pkg::op_t'(operation),
                                                    priority_req, task_id));
            pending_count <= answers_due.size();
        end
    end

endmodule

// File: bench/strict_priority_multi_fifo_scheduler_test.sv
// top of the scheduler testbench: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 100ps

module strict_priority_multi_fifo_scheduler_test;

    // cycles with no word moving on either channel before the run is called hung,
    // and the length of the deliberate receiver hold-off
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SQUEEZE_CYCLES = 120;
    localparam int BURSTS         = 17;
    localparam int BURST_WORDS    = 100;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       operation;
    logic [2:0] priority_req;
    logic [7:0] task_id;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] status;
    logic [7:0] chosen_id;
    logic [2:0] chosen_level;

    int         fail_count;
    int         pending_count;
    int         idle_cycles = 0;

    // flow control knobs shared between processes
    bit         calm_in  = 1'b0;
    bit         calm_out = 1'b0;
    bit         squeeze  = 1'b0;
    bit         squeezed = 1'b0;

    strict_priority_multi_fifo_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .priority_req (priority_req),
        .task_id      (task_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .chosen_id    (chosen_id),
        .chosen_level (chosen_level)
    );

    strict_priority_multi_fifo_scheduler_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .priority_req  (priority_req),
        .task_id       (task_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .chosen_id     (chosen_id),
        .chosen_level  (chosen_level),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // offer one word and hold it until the block takes it; each call starts
    // and ends on the rising edge at which the previous word was accepted,
    // so valid gets exactly one assignment per edge
    task automatic send_word(input spmfs_pkg::op_t op, input logic [2:0] lvl,
                             input logic [7:0] id);
        int gap;
        // occasionally flip between back-to-back offering and random gaps
        if ($urandom_range(0, 63) == 0)
            calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        priority_req <= lvl;
        task_id      <= id;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // receiver: after each accepted result word it draws a stall of random
    // length, possibly none; once, on request, it holds off for a long stretch
    // so the pipeline backs up and in_stall has to rise
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (squeeze && !squeezed)
            begin
                squeezed = 1'b1;
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                if ($urandom_range(0, 99) == 0)
                    calm_out = !calm_out;
                gap = calm_out ? 0 : $urandom_range(0, 12);
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog: any accepted word on either side resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("strict_priority_multi_fifo_scheduler_test: done, errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and verdict
    initial
    begin
        int   add_pct;
        logic [2:0] hot;
        logic [2:0] lvl;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        operation    <= spmfs_pkg::OP_ADD;
        priority_req <= '0;
        task_id      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: take with every level empty
        send_word(spmfs_pkg::OP_TAKE, 3'd0, 8'h00);
        // extremes of level and id, urgency order across levels
        send_word(spmfs_pkg::OP_ADD, 3'd7, 8'hff);
        send_word(spmfs_pkg::OP_ADD, 3'd0, 8'h00);
        send_word(spmfs_pkg::OP_TAKE, 3'd7, 8'hff);
        send_word(spmfs_pkg::OP_TAKE, 3'd0, 8'h00);
        // back to empty after draining
        send_word(spmfs_pkg::OP_TAKE, 3'd5, 8'h5a);
        // fill level 4 to its depth with ids 0, 17 .. 255, then one more add
        // that must be turned away as full
        for (int k = 0; k < 16; k++)
            send_word(spmfs_pkg::OP_ADD, 3'd4, 8'(k * 17));
        send_word(spmfs_pkg::OP_ADD, 3'd4, 8'h33);
        // first two ids come back in order; the rest stay for the random part
        send_word(spmfs_pkg::OP_TAKE, 3'd0, 8'h00);
        send_word(spmfs_pkg::OP_TAKE, 3'd0, 8'h00);

        // long receiver hold-off while words keep coming
        squeeze = 1'b1;

        // random bursts: each burst leans toward adds or takes and favors one
        // hot level, so queues fill to the top, wrap their pointers and drain
        // to empty again, with plenty of full and empty answers along the way
        for (int b = 0; b < BURSTS; b++)
        begin
            add_pct = $urandom_range(15, 90);
            hot     = 3'($urandom_range(0, 7));
            for (int k = 0; k < BURST_WORDS; k++)
            begin
                lvl = $urandom_range(0, 1) ? hot : 3'($urandom_range(0, 7));
                if ($urandom_range(0, 99) < add_pct)
                    send_word(spmfs_pkg::OP_ADD, lvl, 8'($urandom));
                else
                    send_word(spmfs_pkg::OP_TAKE, 3'($urandom), 8'($urandom));
            end
        end
        in_valid <= 1'b0;

        // let the checker count the last word, then wait for every answer
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        // a few more cycles to catch any stray result word
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("strict_priority_multi_fifo_scheduler_test: done, clean");
        else
            $display("strict_priority_multi_fifo_scheduler_test: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/spmfs_pkg.sv
rtl/spmfs_entry_ram.sv
rtl/spmfs_level_pick.sv
rtl/strict_priority_multi_fifo_scheduler.sv
bench/strict_priority_multi_fifo_scheduler_check.sv
bench/strict_priority_multi_fifo_scheduler_test.sv
